FILE: hdl/icds_pkg.sv
// Package for the bus clock divider select block.
// Holds the divider/code ROM, its size and the fixed widths; no dependencies.
`default_nettype none

package icds_pkg;

	localparam int unsigned RomSize   = 50;
	localparam int unsigned IdxW      = 6;
	localparam int unsigned DivW      = 12;
	localparam int unsigned CodeW     = 6;
	localparam int unsigned NumW      = 32;
	localparam int unsigned DenW      = 30;
	localparam int unsigned CntW      = 5;
	localparam logic [18:0] DelayScale = 19'd500000;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(RomSize - 1);

	typedef logic [IdxW-1:0] idx_t;
	typedef logic [DivW-1:0] div_t;
	typedef logic [CodeW-1:0] code_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DIV1   = 6'b000010,
		ST_SEARCH = 6'b000100,
		ST_MUL    = 6'b001000,
		ST_LOAD2  = 6'b010000,
		ST_DIV2   = 6'b100000
	} state_t;

	// divider ratio of a ROM entry, sorted ascending
	function automatic div_t rom_div(input idx_t idx);
		div_t d;
		begin
			case (idx)
				6'd0:  d = 12'd22;   6'd1:  d = 12'd24;   6'd2:  d = 12'd26;
				6'd3:  d = 12'd28;   6'd4:  d = 12'd30;   6'd5:  d = 12'd32;
				6'd6:  d = 12'd36;   6'd7:  d = 12'd40;   6'd8:  d = 12'd42;
				6'd9:  d = 12'd44;   6'd10: d = 12'd48;   6'd11: d = 12'd52;
				6'd12: d = 12'd56;   6'd13: d = 12'd60;   6'd14: d = 12'd64;
				6'd15: d = 12'd72;   6'd16: d = 12'd80;   6'd17: d = 12'd88;
				6'd18: d = 12'd96;   6'd19: d = 12'd104;  6'd20: d = 12'd112;
				6'd21: d = 12'd128;  6'd22: d = 12'd144;  6'd23: d = 12'd160;
				6'd24: d = 12'd192;  6'd25: d = 12'd224;  6'd26: d = 12'd240;
				6'd27: d = 12'd256;  6'd28: d = 12'd288;  6'd29: d = 12'd320;
				6'd30: d = 12'd384;  6'd31: d = 12'd448;  6'd32: d = 12'd480;
				6'd33: d = 12'd512;  6'd34: d = 12'd576;  6'd35: d = 12'd640;
				6'd36: d = 12'd768;  6'd37: d = 12'd896;  6'd38: d = 12'd960;
				6'd39: d = 12'd1024; 6'd40: d = 12'd1152; 6'd41: d = 12'd1280;
				6'd42: d = 12'd1536; 6'd43: d = 12'd1792; 6'd44: d = 12'd1920;
				6'd45: d = 12'd2048; 6'd46: d = 12'd2304; 6'd47: d = 12'd2560;
				6'd48: d = 12'd3072; 6'd49: d = 12'd3840;
				default: d = 12'd3840;
			endcase
			return d;
		end
	endfunction

	// register code of a ROM entry
	function automatic code_t rom_code(input idx_t idx);
		code_t c;
		begin
			case (idx)
				6'd0:  c = 6'h20; 6'd1:  c = 6'h21; 6'd2:  c = 6'h22; 6'd3:  c = 6'h23;
				6'd4:  c = 6'h00; 6'd5:  c = 6'h24; 6'd6:  c = 6'h25; 6'd7:  c = 6'h26;
				6'd8:  c = 6'h03; 6'd9:  c = 6'h27; 6'd10: c = 6'h28; 6'd11: c = 6'h05;
				6'd12: c = 6'h29; 6'd13: c = 6'h06; 6'd14: c = 6'h2A; 6'd15: c = 6'h2B;
				6'd16: c = 6'h2C; 6'd17: c = 6'h09; 6'd18: c = 6'h2D; 6'd19: c = 6'h0A;
				6'd20: c = 6'h2E; 6'd21: c = 6'h2F; 6'd22: c = 6'h0C; 6'd23: c = 6'h30;
				6'd24: c = 6'h31; 6'd25: c = 6'h32; 6'd26: c = 6'h0F; 6'd27: c = 6'h33;
				6'd28: c = 6'h10; 6'd29: c = 6'h34; 6'd30: c = 6'h35; 6'd31: c = 6'h36;
				6'd32: c = 6'h13; 6'd33: c = 6'h37; 6'd34: c = 6'h14; 6'd35: c = 6'h38;
				6'd36: c = 6'h39; 6'd37: c = 6'h3A; 6'd38: c = 6'h17; 6'd39: c = 6'h3B;
				6'd40: c = 6'h18; 6'd41: c = 6'h3C; 6'd42: c = 6'h3D; 6'd43: c = 6'h3E;
				6'd44: c = 6'h1B; 6'd45: c = 6'h3F; 6'd46: c = 6'h1C; 6'd47: c = 6'h1D;
				6'd48: c = 6'h1E; 6'd49: c = 6'h1F;
				default: c = 6'h1F;
			endcase
			return c;
		end
	endfunction

endpackage

`default_nettype wire

FILE: hdl/icds_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on icds_pkg for widths.
`default_nettype none

module icds_div
	import icds_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            go,
	input  wire logic [NumW-1:0] numer,
	input  wire logic [DenW-1:0] denom,
	output logic                 done,
	output logic [NumW-1:0]      quot
);

	logic [NumW-1:0] num_q;
	logic [DenW-1:0] den_q;
	logic [DenW:0]   rem_q;
	logic [CntW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;

	logic [DenW:0] sh;
	logic          ge;

	assign sh = {rem_q[DenW-1:0], num_q[NumW-1]};
	assign ge = (sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(NumW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift into the low end of the numerator register
	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[NumW-2:0], ge};
			rem_q <= ge ? (sh - {1'b0, den_q}) : sh;
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

`default_nettype wire

FILE: hdl/i2c_clock_divider_select.sv
// Bus clock divider select: required divider, ROM lookup and stop delay.
// Each request makes two passes through the shared divider, with five or six search
// steps between them; a new request is taken only when idle, and busy drops in the
// done cycle.
// Reset: asynchronous, active low; returns to idle with no result pending.
// The receiver cannot stall: done is high for one cycle only, and the result fields change once the next request runs.
`default_nettype none

module i2c_clock_divider_select
	import icds_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [29:0] clock_rate,
	input  wire logic [19:0] target_rate,
	output logic             done,
	output logic [5:0]       divider_code,
	output logic [11:0]      actual_divider,
	output logic [30:0]      stop_delay_us
);

	state_t state_q;

	logic [29:0] clk_q;
	logic        inf_q;       // zero target rate: divider unbounded
	logic [30:0] need_q;      // required divider, ceil(clock / rate)
	idx_t        lo_q;
	idx_t        hi_q;
	logic [30:0] prod_q;      // 500000 * chosen divider
	logic        done_q;
	code_t       code_q;
	div_t        adiv_q;
	logic [30:0] delay_q;

	// shared divider
	logic            div_go;
	logic [NumW-1:0] div_num;
	logic [DenW-1:0] div_den;
	logic            div_done;
	logic [NumW-1:0] div_quot;

	logic        accept;
	logic [6:0]  mid_sum;
	idx_t        mid;
	logic        mid_ok;
	logic [28:0] half;
	div_t        lo_div;

	assign accept  = start && (state_q == ST_IDLE);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[IdxW:1];
	// entry at mid is large enough for the requirement
	assign mid_ok  = !inf_q && ({19'b0, rom_div(mid)} >= need_q);
	assign lo_div  = rom_div(lo_q);
	// half clock, held at one when the clock is below two
	assign half    = (clk_q[29:1] == '0) ? 29'd1 : clk_q[29:1];

	// the divider is loaded on the accept cycle (requirement) and from
	// ST_LOAD2 (delay); its operands are muxed here
	always_comb begin
		div_go  = 1'b0;
		div_num = {2'b0, clock_rate} + {12'b0, target_rate} - NumW'(1);
		div_den = {10'b0, target_rate};
		if (accept) begin
			div_go = 1'b1;
		end else if (state_q == ST_LOAD2) begin
			div_go  = 1'b1;
			div_num = {1'b0, prod_q} + {3'b0, half} - NumW'(1);
			div_den = {1'b0, half};
		end
	end

	icds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.numer  (div_num),
		.denom  (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_DIV1;
				end
				ST_DIV1: begin
					if (div_done) state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (lo_q == hi_q) state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_LOAD2;
				end
				ST_LOAD2: begin
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					if (div_done) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			clk_q <= clock_rate;
			inf_q <= (target_rate == '0);
		end
		if (state_q == ST_DIV1 && div_done) begin
			need_q <= div_quot[30:0];
			lo_q   <= '0;
			hi_q   <= LastIdx;
		end
		// lower-bound binary search; ends on the last entry if none fits
		if (state_q == ST_SEARCH && lo_q != hi_q) begin
			if (mid_ok) hi_q <= mid;
			else        lo_q <= mid + 1'b1;
		end
		if (state_q == ST_MUL) begin
			prod_q <= {12'b0, DelayScale} * {19'b0, lo_div};
			code_q <= rom_code(lo_q);
			adiv_q <= lo_div;
		end
		if (state_q == ST_DIV2 && div_done) begin
			delay_q <= div_quot[30:0];
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign divider_code   = code_q;
	assign actual_divider = adiv_q;
	assign stop_delay_us  = delay_q;

endmodule

`default_nettype wire

FILE: verif/divider_select_checker.sv
`timescale 1ns / 1ps
// Checker for the bus clock divider select block: predicts each divider setting and compares.
// Depends on icds_pkg for widths, the ROM size and the delay scale.
module divider_select_checker
	import icds_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [29:0] clock_rate,
	input  logic [19:0] target_rate,
	input  logic        done,
	input  logic [5:0]  divider_code,
	input  logic [11:0] actual_divider,
	input  logic [30:0] stop_delay_us,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		code_t       code;
		div_t        ratio;
		logic [30:0] delay;
	} bus_setting_t;

	// divider ladder, ascending, with its register codes
	localparam logic [11:0] RatioTbl [RomSize] = '{
		12'd22, 12'd24, 12'd26, 12'd28, 12'd30, 12'd32, 12'd36, 12'd40, 12'd42, 12'd44,
		12'd48, 12'd52, 12'd56, 12'd60, 12'd64, 12'd72, 12'd80, 12'd88, 12'd96, 12'd104,
		12'd112, 12'd128, 12'd144, 12'd160, 12'd192, 12'd224, 12'd240, 12'd256, 12'd288,
		12'd320, 12'd384, 12'd448, 12'd480, 12'd512, 12'd576, 12'd640, 12'd768, 12'd896,
		12'd960, 12'd1024, 12'd1152, 12'd1280, 12'd1536, 12'd1792, 12'd1920, 12'd2048,
		12'd2304, 12'd2560, 12'd3072, 12'd3840
	};
	localparam logic [5:0] CodeTbl [RomSize] = '{
		6'h20, 6'h21, 6'h22, 6'h23, 6'h00, 6'h24, 6'h25, 6'h26, 6'h03, 6'h27,
		6'h28, 6'h05, 6'h29, 6'h06, 6'h2A, 6'h2B, 6'h2C, 6'h09, 6'h2D, 6'h0A,
		6'h2E, 6'h2F, 6'h0C, 6'h30, 6'h31, 6'h32, 6'h0F, 6'h33, 6'h10, 6'h34,
		6'h35, 6'h36, 6'h13, 6'h37, 6'h14, 6'h38, 6'h39, 6'h3A, 6'h17, 6'h3B,
		6'h18, 6'h3C, 6'h3D, 6'h3E, 6'h1B, 6'h3F, 6'h1C, 6'h1D, 6'h1E, 6'h1F
	};

	bus_setting_t expected_settings[$];
	int           fail_tally = 0;

	function automatic bus_setting_t predict_setting(input logic [29:0] clk_hz,
			input logic [19:0] rate_hz);
		logic [63:0]  need;
		logic [63:0]  half;
		logic [63:0]  num;
		logic [63:0]  delay;
		int           pick;
		bus_setting_t s;
		// zero rate: divider unbounded, lands on the last rung
		if (rate_hz == 0)
			need = '1;
		else
			need = (64'(clk_hz) + 64'(rate_hz) - 64'd1) / 64'(rate_hz);
		pick = RomSize - 1;
		for (int k = RomSize - 2; k >= 0; k--)
			if (64'(RatioTbl[k]) >= need)
				pick = k;
		half = 64'(clk_hz) >> 1;
		if (half == 0)
			half = 64'd1;
		num = 64'(DelayScale) * 64'(RatioTbl[pick]);
		delay = (num + half - 64'd1) / half;
		s.code = CodeTbl[pick];
		s.ratio = RatioTbl[pick];
		s.delay = delay[30:0];
		return s;
	endfunction

	always @(posedge clk) begin
		bus_setting_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_settings.size() == 0) begin
					$display("%0t: result with no request outstanding (code %0d divider %0d delay %0d)",
						$time, divider_code, actual_divider, stop_delay_us);
					fail_tally++;
				end else begin
					want = expected_settings.pop_front();
					if (divider_code !== want.code) begin
						$display("%0t: divider_code expected %0d got %0d",
							$time, want.code, divider_code);
						fail_tally++;
					end
					if (actual_divider !== want.ratio) begin
						$display("%0t: actual_divider expected %0d got %0d",
							$time, want.ratio, actual_divider);
						fail_tally++;
					end
					if (stop_delay_us !== want.delay) begin
						$display("%0t: stop_delay_us expected %0d got %0d",
							$time, want.delay, stop_delay_us);
						fail_tally++;
					end
				end
			end
			if (start && !busy)
				expected_settings.push_back(predict_setting(clock_rate, target_rate));
		end
		errors <= fail_tally;
		pending <= expected_settings.size();
	end

endmodule

FILE: verif/i2c_clock_divider_select_test.sv
`timescale 1ns / 1ps
// Testbench top for the bus clock divider select block: stimulus, watchdog and verdict.
// Depends on icds_pkg, the block itself and divider_select_checker.
module i2c_clock_divider_select_test;
	import icds_pkg::*;

	localparam int CycleLimit     = 1_000_000;
	localparam int RandomRequests = 830;
	// longer than the block's worst latency
	localparam int SettleCycles   = 100;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [29:0] clock_rate;
	logic [19:0] target_rate;
	logic        done;
	logic [5:0]  divider_code;
	logic [11:0] actual_divider;
	logic [30:0] stop_delay_us;
	int          errors;
	int          pending;
	int          cycles = 0;

	i2c_clock_divider_select dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.clock_rate     (clock_rate),
		.target_rate    (target_rate),
		.done           (done),
		.divider_code   (divider_code),
		.actual_divider (actual_divider),
		.stop_delay_us  (stop_delay_us)
	);

	// prediction and comparison live here; we only read back the tallies
	divider_select_checker setting_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.clock_rate     (clock_rate),
		.target_rate    (target_rate),
		.done           (done),
		.divider_code   (divider_code),
		.actual_divider (actual_divider),
		.stop_delay_us  (stop_delay_us),
		.errors         (errors),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung block or a lost result ends up here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// mostly back-to-back, some short pauses, the odd long one
	function automatic int idle_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 4);
		return $urandom_range(20, 200);
	endfunction

	// Present one request and hold it until the block takes it (start high, busy low
	// at the edge). With no gap, start stays high and the next request follows at once;
	// otherwise start drops and junk sits on the fields while idle.
	task automatic send_request(input logic [29:0] clk_hz, input logic [19:0] rate_hz);
		int gap;
		gap = idle_gap();
		start <= 1'b1;
		clock_rate <= clk_hz;
		target_rate <= rate_hz;
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			clock_rate <= 30'($urandom());
			target_rate <= 20'($urandom());
			repeat (gap) @(posedge clk);
		end
	endtask

	// Aim at a chosen rung: required divider just below, on, or just above it,
	// with a clock that makes the ceiling land exactly there.
	task automatic send_aimed();
		logic [63:0] need;
		logic [63:0] lim;
		logic [63:0] rate;
		logic [63:0] clk_hz;
		int          k;
		k = $urandom_range(0, RomSize - 1);
		need = 64'(rom_div(idx_t'(k))) + 64'($urandom_range(0, 2)) - 64'd1;
		lim = 64'h3FFF_FFFF / need;
		if (lim > 64'hF_FFFF)
			lim = 64'hF_FFFF;
		if ($urandom_range(0, 3) == 0)
			rate = 64'($urandom_range(1, 20));
		else
			rate = 64'($urandom_range(1, 32'(lim)));
		clk_hz = (need - 64'd1) * rate + 64'($urandom_range(1, 32'(rate)));
		send_request(clk_hz[29:0], rate[19:0]);
	endtask

	// hold off until every outstanding request has produced its result
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int pick;
		start <= 1'b0;
		clock_rate <= '0;
		target_rate <= '0;
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: typical rates, both table ends, exact rungs and one past them
		send_request(30'd100_000_000, 20'd100_000);
		send_request(30'd24_000_000, 20'd400_000);
		send_request(30'd66_500_000, 20'd100_000);
		send_request(30'd2, 20'd1);
		send_request(30'd2, 20'd1_000_000);
		send_request(30'd3, 20'd1);
		send_request(30'd1_000_000_000, 20'd1);
		send_request(30'd22_000, 20'd1_000);
		send_request(30'd22_001, 20'd1_000);
		send_request(30'd3_072_001, 20'd1_000);
		send_request(30'd3_840_000, 20'd1_000);
		send_request(30'd3_840_001, 20'd1_000);
		// zero rate: required divider unbounded
		send_request(30'd1_000_000_000, 20'd0);
		send_request(30'd66_000_000, 20'd0);
		// clock below two: half clock held at one, delay gets large
		send_request(30'd0, 20'd100);
		send_request(30'd1, 20'd1);
		send_request(30'd1, 20'd0);
		send_request(30'd0, 20'd0);
		send_request(30'd0, 20'hF_FFFF);
		// all-ones fields
		send_request(30'h3FFF_FFFF, 20'hF_FFFF);
		send_request(30'h3FFF_FFFF, 20'd1);
		wait_drained();

		// random: mostly aimed at rungs, some raw fields, some corner-heavy
		for (int n = 0; n < RandomRequests; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 2)
				send_request(30'($urandom()), 20'($urandom()));
			else if (pick == 2)
				send_request($urandom_range(0, 1) ? 30'($urandom_range(0, 3)) : 30'($urandom()),
					20'($urandom_range(0, 16)));
			else
				send_aimed();
			if ($urandom_range(0, 63) == 0)
				wait_drained();
		end

		wait_drained();
		// catch any stray strobe after the last result
		repeat (SettleCycles) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: files.f
hdl/icds_pkg.sv
hdl/icds_div.sv
hdl/i2c_clock_divider_select.sv
verif/divider_select_checker.sv
verif/i2c_clock_divider_select_test.sv
